>>> hw/rtl/sdmix_pkg.sv
// Shared types, register indexes and ramp function for the stereo downmix block.
package sdmix_pkg;

    localparam int SampleWidth = 16;
    localparam int GainWidth   = 16;
    localparam int FracBits    = 14;
    localparam int CfgIdxWidth = 3;

    typedef logic signed [SampleWidth-1:0] sample_t;
    typedef logic        [GainWidth-1:0]   gain_t;
    typedef logic        [CfgIdxWidth-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_START_LEFT   = 3'd0;
    localparam cfg_idx_t REG_START_RIGHT  = 3'd1;
    localparam cfg_idx_t REG_TARGET_LEFT  = 3'd2;
    localparam cfg_idx_t REG_TARGET_RIGHT = 3'd3;
    localparam cfg_idx_t REG_RAMP_STEP    = 3'd4;

    localparam gain_t GAIN_UNITY = 16'd16384;
    localparam gain_t STEP_RESET = 16'd0;

    typedef struct packed {
        gain_t left;
        gain_t right;
    } gain_pair_t;

    // One accepted transaction as held in the input register.
    typedef struct packed {
        sample_t    left_sample;
        sample_t    right_sample;
        gain_pair_t mix_gain;
        gain_pair_t gain_now;
    } mix_op_t;

    typedef struct packed {
        sample_t    mono_sample;
        logic       clipped;
        gain_pair_t gain_now;
    } mix_res_t;

    function automatic gain_t ramp_toward(gain_t g, gain_t t, gain_t step);
        gain_t diff;
        gain_t result;
        begin
            result = g;
            if (g > t)
            begin
                diff   = g - t;
                result = (diff > step) ? gain_t'(g - step) : t;
            end
            else if (g < t)
            begin
                diff   = t - g;
                result = (diff > step) ? gain_t'(g + step) : t;
            end
            return result;
        end
    endfunction

endpackage

>>> hw/rtl/sdmix_gain_ramp.sv
// Configuration registers and the per-sample gain ramp state.
module sdmix_gain_ramp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  sdmix_pkg::cfg_idx_t  cfg_index,
    input  sdmix_pkg::gain_t     cfg_data,
    input  logic                 advance,
    input  logic                 first_of_buffer,
    output sdmix_pkg::gain_pair_t mix_gain,
    output sdmix_pkg::gain_pair_t gain_now
);
    import sdmix_pkg::*;

    gain_pair_t start_reg;
    gain_pair_t target_reg;
    gain_t      step_reg;
    gain_pair_t gain_reg;
    gain_pair_t gain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '{left: GAIN_UNITY, right: GAIN_UNITY};
            target_reg <= '{left: GAIN_UNITY, right: GAIN_UNITY};
            step_reg   <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_LEFT:   start_reg.left   <= cfg_data;
                REG_START_RIGHT:  start_reg.right  <= cfg_data;
                REG_TARGET_LEFT:  target_reg.left  <= cfg_data;
                REG_TARGET_RIGHT: target_reg.right <= cfg_data;
                REG_RAMP_STEP:    step_reg         <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Load start gains on a buffer start, then ramp once per transaction.
    always_comb
    begin
        mix_gain        = first_of_buffer ? start_reg : gain_reg;
        gain_now.left   = ramp_toward(mix_gain.left, target_reg.left, step_reg);
        gain_now.right  = ramp_toward(mix_gain.right, target_reg.right, step_reg);
        gain_next       = advance ? gain_now : gain_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= '{left: GAIN_UNITY, right: GAIN_UNITY};
        else
            gain_reg <= gain_next;
    end

    gain_pair_t gain_past_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_past_reg <= '{left: GAIN_UNITY, right: GAIN_UNITY};
        else
            gain_past_reg <= gain_reg;
    end

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> gain_reg == gain_past_reg)
        else $error("gain moved without a transaction");

    a_zero_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_RESET && !first_of_buffer) |-> gain_now == gain_reg)
        else $error("gain ramped with a zero step");

    a_ramp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_gain.left <= target_reg.left) |-> gain_now.left <= target_reg.left)
        else $error("left gain overshot its target");

endmodule

>>> hw/rtl/sdmix_mixer.sv
// Mix stage: two products, truncating scale, saturation and the result register.
module sdmix_mixer (
    input  logic                clk,
    input  logic                load,
    input  sdmix_pkg::mix_op_t  op,
    output sdmix_pkg::mix_res_t res
);
    import sdmix_pkg::*;

    localparam int ProdWidth = SampleWidth + GainWidth + 1;
    localparam int SumWidth  = ProdWidth + 1;
    localparam int QuotWidth = SumWidth - FracBits;

    localparam logic signed [QuotWidth-1:0] QMax = QuotWidth'(32767);
    localparam logic signed [QuotWidth-1:0] QMin = -QuotWidth'(32768);
    localparam logic signed [SumWidth-1:0]  Bias = SumWidth'((1 << FracBits) - 1);

    logic signed [ProdWidth-1:0] prod_l;
    logic signed [ProdWidth-1:0] prod_r;
    logic signed [SumWidth-1:0]  sum;
    logic signed [SumWidth-1:0]  biased;
    logic signed [QuotWidth-1:0] quot;
    mix_res_t                    res_next;
    mix_res_t                    res_reg;

    always_comb
    begin
        prod_l = op.left_sample * $signed({1'b0, op.mix_gain.left});
        prod_r = op.right_sample * $signed({1'b0, op.mix_gain.right});
        sum    = SumWidth'(prod_l) + SumWidth'(prod_r);
        // Bias negative sums so the arithmetic shift truncates toward zero.
        biased = sum[SumWidth-1] ? sum + Bias : sum;
        quot   = biased[SumWidth-1:FracBits];

        res_next.gain_now = op.gain_now;
        priority if (quot > QMax)
        begin
            res_next.mono_sample = sample_t'(QMax);
            res_next.clipped     = 1'b1;
        end
        else if (quot < QMin)
        begin
            res_next.mono_sample = sample_t'(QMin);
            res_next.clipped     = 1'b1;
        end
        else
        begin
            res_next.mono_sample = quot[SampleWidth-1:0];
            res_next.clipped     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

>>> hw/rtl/stereo_downmix_gain_ramp.sv
// Top level of the stereo to mono downmix with linear gain ramp.
//
// Input channel (sample_valid / sample_stall) carries one stereo pair and a
// buffer-start mark per transaction; output channel (mix_valid / mix_stall)
// returns one mono sample, a clip flag and the gains after this sample's
// ramp update. Configuration is written through cfg_valid / cfg_ready with a
// register index and 16-bit data; cfg_ready is always high, and writes are
// expected only while no transaction is in flight.
// A transaction passes through the input register, which holds the samples
// and the gains used for mixing, and then the result register, which holds
// the saturated mix. Throughput is one transaction per cycle unless stalled.
// The ramp is updated in the cycle a transaction is accepted, so the next
// pair sees the new gains straight away.
// Reset clears both valid flags and restores start and target gains to unity
// (16384 in Q2.14), ramp step to zero and the running gains to unity.
// When the receiver stalls, the result holds; the input register can still
// take one more transaction, after which sample_stall rises.
module stereo_downmix_gain_ramp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  sdmix_pkg::sample_t  left_sample,
    input  sdmix_pkg::sample_t  right_sample,
    input  logic                first_of_buffer,
    output logic                mix_valid,
    input  logic                mix_stall,
    output sdmix_pkg::sample_t  mono_sample,
    output logic                clipped,
    output sdmix_pkg::gain_t    left_gain_now,
    output sdmix_pkg::gain_t    right_gain_now,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  sdmix_pkg::cfg_idx_t cfg_index,
    input  sdmix_pkg::gain_t    cfg_data
);
    import sdmix_pkg::*;

    logic       op_valid_reg;
    logic       op_valid_next;
    mix_op_t    op_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       res_load;
    logic       op_free;
    logic       accept;
    gain_pair_t mix_gain;
    gain_pair_t gain_now;
    mix_res_t   res;

    assign cfg_ready = 1'b1;

    assign res_load     = !res_valid_reg || !mix_stall;
    assign op_free      = !op_valid_reg || res_load;
    assign sample_stall = !op_free;
    assign accept       = sample_valid && op_free;

    sdmix_gain_ramp u_gain (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .advance         (accept),
        .first_of_buffer (first_of_buffer),
        .mix_gain        (mix_gain),
        .gain_now        (gain_now)
    );

    always_comb
    begin
        op_valid_next  = op_free ? sample_valid : op_valid_reg;
        res_valid_next = res_load ? op_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg.left_sample  <= left_sample;
            op_reg.right_sample <= right_sample;
            op_reg.mix_gain     <= mix_gain;
            op_reg.gain_now     <= gain_now;
        end
    end

    sdmix_mixer u_mixer (
        .clk  (clk),
        .load (res_load && op_valid_reg),
        .op   (op_reg),
        .res  (res)
    );

    assign mix_valid      = res_valid_reg;
    assign mono_sample    = res.mono_sample;
    assign clipped        = res.clipped;
    assign left_gain_now  = res.gain_now.left;
    assign right_gain_now = res.gain_now.right;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (op_valid_reg && res_valid_reg && mix_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_op: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> op_valid_reg)
        else $error("accepted transaction lost from input register");

    a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_valid && clipped) |->
            (mono_sample == 16'sh7fff || mono_sample == 16'sh8000))
        else $error("clip flag without a saturated sample");

    a_op_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid_reg && !res_valid_reg) |=> res_valid_reg)
        else $error("input register did not drain into an empty result stage");

endmodule
